// ===== hdl/annealing_graph_coloring_move_macros.svh =====
// Assertion helpers for the annealing move engine
`ifndef ANNEALING_GRAPH_COLORING_MOVE_MACROS_SVH
`define ANNEALING_GRAPH_COLORING_MOVE_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define AGCM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("agcm assertion failed");

// next-cycle implication, clocked on clk, off during reset
`define AGCM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("agcm assertion failed");

`endif

// ===== hdl/agcm_pkg.sv =====
`timescale 1ns / 1ps
package agcm_pkg;

  localparam int MAX_VERTICES = 512;
  localparam int NUM_COLORS   = 70;
  localparam int MAX_DEGREE   = 511;

  localparam int VW         = $clog2(MAX_VERTICES);
  localparam int CLW        = 7;
  localparam int DGW        = $clog2(MAX_DEGREE + 1);
  localparam int CNTW       = DGW;
  localparam int CNT_DEPTH  = MAX_VERTICES * NUM_COLORS;
  localparam int CNT_AW     = $clog2(CNT_DEPTH);
  localparam int LIST_DEPTH = MAX_VERTICES * MAX_DEGREE;
  localparam int LIST_AW    = $clog2(LIST_DEPTH);
  localparam int TOT_W      = 17;
  localparam int DELTA_W    = 10;
  localparam int BOUND_W    = 16;

  typedef enum logic [1:0] {
    OP_SET_COLOR,
    OP_ADD_EDGE,
    OP_PROPOSE,
    OP_NOP
  } op_t;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_FETCH, ST_DECODE, ST_RD_NEW, ST_RD_OLD, ST_EVAL,
    ST_W_LIST, ST_W_OLD, ST_W_NEW, ST_W_INC, ST_S_LIST, ST_S_CMP, ST_RD_B,
    ST_GOT_B, ST_L2, ST_L3, ST_L4, ST_FIN, ST_DONE
  } state_t;

  // write/read requests toward the four memories
  typedef struct packed {
    logic               col_we;
    logic [VW-1:0]      col_waddr;
    logic [CLW-1:0]     col_wdata;
    logic [VW-1:0]      col_raddr;
    logic               deg_we;
    logic [VW-1:0]      deg_waddr;
    logic [DGW-1:0]     deg_wdata;
    logic [VW-1:0]      deg_raddr;
    logic               list_we;
    logic [LIST_AW-1:0] list_waddr;
    logic [VW-1:0]      list_wdata;
    logic [LIST_AW-1:0] list_raddr;
    logic               cnt_we;
    logic [CNT_AW-1:0]  cnt_waddr;
    logic [CNTW-1:0]    cnt_wdata;
    logic [CNT_AW-1:0]  cnt_raddr;
  } mem_req_t;

  // registered read data back from the memories
  typedef struct packed {
    logic [CLW-1:0]  col;
    logic [DGW-1:0]  deg;
    logic [VW-1:0]   list;
    logic [CNTW-1:0] cnt;
  } mem_rd_t;

  function automatic logic [CNT_AW-1:0] cnt_addr(input logic [VW-1:0] v,
                                                 input logic [CLW-1:0] c);
    cnt_addr = CNT_AW'(v * NUM_COLORS + c);
  endfunction

  function automatic logic [LIST_AW-1:0] list_addr(input logic [VW-1:0] v,
                                                   input logic [DGW-1:0] k);
    list_addr = LIST_AW'(v * MAX_DEGREE + k);
  endfunction

endpackage

// ===== hdl/annealing_graph_coloring_move.sv =====
`timescale 1ns / 1ps
// Annealing move engine for graph k-coloring. After reset the block clears its
// neighbor-count memory, one entry a cycle, along with the color and degree
// memories, and holds busy high until the clear ends. An item is taken when
// start is high and busy is low; one result per item appears with done for
// exactly one cycle and must be captured then, as the receiver cannot stall it.
// An applied recolor walks the vertex's neighbor list, with one count memory
// port: a decrement and an increment per neighbor. Add edge first scans the
// first vertex's neighbor list for the second vertex.
module annealing_graph_coloring_move (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        operation,
  input  logic [agcm_pkg::VW-1:0]           vertex_a,
  input  logic [agcm_pkg::VW-1:0]           vertex_b,
  input  logic [agcm_pkg::CLW-1:0]          color,
  input  logic [agcm_pkg::BOUND_W-1:0]      accept_bound,
  output logic                              done,
  output logic                              accepted,
  output logic signed [agcm_pkg::DELTA_W-1:0] delta,
  output logic [agcm_pkg::TOT_W-1:0]        conflicts,
  output logic [agcm_pkg::TOT_W-1:0]        best_conflicts,
  output logic                              list_full
);
  import agcm_pkg::*;
  `include "annealing_graph_coloring_move_macros.svh"

  mem_req_t req;
  mem_rd_t  rd;
  logic [DELTA_W-1:0] delta_u;

  assign delta = $signed(delta_u);

  agcm_ctrl u_ctrl (
    .clk, .rst, .start, .busy, .operation, .vertex_a, .vertex_b, .color,
    .accept_bound, .req, .rd, .done, .accepted, .delta(delta_u), .conflicts,
    .best_conflicts, .list_full
  );

  // vertex colors
  agcm_ram #(.W(CLW), .D(MAX_VERTICES)) u_color (
    .clk, .we(req.col_we), .waddr(req.col_waddr), .wdata(req.col_wdata),
    .raddr(req.col_raddr), .rdata(rd.col)
  );

  // vertex degrees
  agcm_ram #(.W(DGW), .D(MAX_VERTICES)) u_degree (
    .clk, .we(req.deg_we), .waddr(req.deg_waddr), .wdata(req.deg_wdata),
    .raddr(req.deg_raddr), .rdata(rd.deg)
  );

  // neighbor lists
  agcm_ram #(.W(VW), .D(LIST_DEPTH)) u_list (
    .clk, .we(req.list_we), .waddr(req.list_waddr), .wdata(req.list_wdata),
    .raddr(req.list_raddr), .rdata(rd.list)
  );

  // per-vertex neighbor color counts
  agcm_ram #(.W(CNTW), .D(CNT_DEPTH)) u_count (
    .clk, .we(req.cnt_we), .waddr(req.cnt_waddr), .wdata(req.cnt_wdata),
    .raddr(req.cnt_raddr), .rdata(rd.cnt)
  );

  // checks
  `AGCM_ASSERT_NEXT(a_done_single, done, !done)
  `AGCM_ASSERT_NEXT(a_start_busy, start && !busy, busy)
  `AGCM_ASSERT_NOW(a_best_le, done && accepted, best_conflicts <= conflicts)
  `AGCM_ASSERT_NOW(a_full_quiet, done && list_full, !accepted && delta == 0)

endmodule

// ===== hdl/agcm_ram.sv =====
`timescale 1ns / 1ps
module agcm_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/agcm_ctrl.sv =====
`timescale 1ns / 1ps
module agcm_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [1:0]              operation,
  input  logic [agcm_pkg::VW-1:0] vertex_a,
  input  logic [agcm_pkg::VW-1:0] vertex_b,
  input  logic [agcm_pkg::CLW-1:0] color,
  input  logic [agcm_pkg::BOUND_W-1:0] accept_bound,
  output agcm_pkg::mem_req_t      req,
  input  agcm_pkg::mem_rd_t       rd,
  output logic                    done,
  output logic                    accepted,
  output logic [agcm_pkg::DELTA_W-1:0] delta,
  output logic [agcm_pkg::TOT_W-1:0] conflicts,
  output logic [agcm_pkg::TOT_W-1:0] best_conflicts,
  output logic                    list_full
);
  import agcm_pkg::*;

  state_t state, state_next;

  op_t               op;
  logic [VW-1:0]     va, vb, nbr;
  logic [CLW-1:0]    col, cur, cb;
  logic [BOUND_W-1:0] bound;
  logic [DGW-1:0]    deg_a, deg_b, k;
  logic [CNTW-1:0]   cnt_new;
  logic [CNT_AW-1:0] clr_addr;

  // evaluation of a set-color or proposal, with rd.cnt holding the old-color count
  logic [DELTA_W-1:0] delta_w;
  logic               considered, bound_ok, apply;
  logic signed [TOT_W:0] sum_w;
  logic [TOT_W-1:0]   conf_upd;
  logic               col_ok, va_ok, vb_ok, full_w, clr_last;

  assign col_ok   = col < CLW'(NUM_COLORS);
  assign va_ok    = {1'b0, va} < (VW + 1)'(MAX_VERTICES);
  assign vb_ok    = {1'b0, vb} < (VW + 1)'(MAX_VERTICES);
  assign delta_w  = {1'b0, cnt_new} - {1'b0, rd.cnt};
  assign bound_ok = delta_w[DELTA_W-1] ||
                    ({delta_w[CNTW-1:0], 8'd0} < {1'b0, bound});
  assign considered = (op == OP_SET_COLOR) || (rd.cnt != '0);
  assign apply    = considered && ((op == OP_SET_COLOR) || bound_ok);
  assign sum_w    = $signed({1'b0, conflicts}) +
                    $signed({{(TOT_W + 1 - DELTA_W){delta_w[DELTA_W-1]}}, delta_w});
  assign conf_upd = sum_w[TOT_W] ? '0 : sum_w[TOT_W-1:0];
  assign full_w   = (deg_a >= DGW'(MAX_DEGREE)) || (rd.deg >= DGW'(MAX_DEGREE));
  assign clr_last = clr_addr == CNT_AW'(CNT_DEPTH - 1);

  assign busy = state != ST_IDLE;
  assign done = state == ST_DONE;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_last) state_next = ST_IDLE;
      ST_IDLE:   if (start) state_next = ST_FETCH;
      ST_FETCH:  state_next = ST_DECODE;
      ST_DECODE: begin
        unique case (op)
          OP_SET_COLOR, OP_PROPOSE: begin
            if (!va_ok || !col_ok || rd.col == col) state_next = ST_FIN;
            else state_next = ST_RD_NEW;
          end
          OP_ADD_EDGE: begin
            if (!va_ok || !vb_ok || va == vb) state_next = ST_FIN;
            else state_next = ST_S_LIST;
          end
          default: state_next = ST_FIN;
        endcase
      end
      ST_RD_NEW: state_next = ST_RD_OLD;
      ST_RD_OLD: state_next = ST_EVAL;
      ST_EVAL:   state_next = apply ? ST_W_LIST : ST_FIN;
      ST_W_LIST: state_next = (k == deg_a) ? ST_FIN : ST_W_OLD;
      ST_W_OLD:  state_next = ST_W_NEW;
      ST_W_NEW:  state_next = ST_W_INC;
      ST_W_INC:  state_next = ST_W_LIST;
      ST_S_LIST: state_next = (k == deg_a) ? ST_RD_B : ST_S_CMP;
      ST_S_CMP:  state_next = (rd.list == vb) ? ST_FIN : ST_S_LIST;
      ST_RD_B:   state_next = ST_GOT_B;
      ST_GOT_B:  state_next = full_w ? ST_FIN : ST_L2;
      ST_L2:     state_next = ST_L3;
      ST_L3:     state_next = ST_L4;
      ST_L4:     state_next = ST_FIN;
      ST_FIN:    state_next = ST_DONE;
      ST_DONE:   state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // memory requests
  always_comb begin
    req = '0;
    req.col_raddr = va;
    req.deg_raddr = va;
    unique case (state)
      ST_CLEAR: begin
        req.cnt_we    = 1'b1;
        req.cnt_waddr = clr_addr;
        req.col_we    = clr_addr < CNT_AW'(MAX_VERTICES);
        req.col_waddr = clr_addr[VW-1:0];
        req.deg_we    = req.col_we;
        req.deg_waddr = clr_addr[VW-1:0];
      end
      ST_RD_NEW: req.cnt_raddr = cnt_addr(va, col);
      ST_RD_OLD: req.cnt_raddr = cnt_addr(va, cur);
      ST_EVAL: begin
        req.col_we    = apply;
        req.col_waddr = va;
        req.col_wdata = col;
      end
      ST_W_LIST, ST_S_LIST: req.list_raddr = list_addr(va, k);
      ST_W_OLD:  req.cnt_raddr = cnt_addr(rd.list, cur);
      ST_W_NEW: begin
        req.cnt_we    = 1'b1;
        req.cnt_waddr = cnt_addr(nbr, cur);
        req.cnt_wdata = (rd.cnt == '0) ? '0 : rd.cnt - 1'b1;
        req.cnt_raddr = cnt_addr(nbr, col);
      end
      ST_W_INC: begin
        req.cnt_we    = 1'b1;
        req.cnt_waddr = cnt_addr(nbr, col);
        req.cnt_wdata = rd.cnt + 1'b1;
      end
      ST_RD_B: begin
        req.col_raddr = vb;
        req.deg_raddr = vb;
      end
      ST_GOT_B: begin
        req.list_we    = !full_w;
        req.list_waddr = list_addr(va, deg_a);
        req.list_wdata = vb;
        req.deg_we     = !full_w;
        req.deg_waddr  = va;
        req.deg_wdata  = deg_a + 1'b1;
      end
      ST_L2: begin
        req.list_we    = 1'b1;
        req.list_waddr = list_addr(vb, deg_b);
        req.list_wdata = va;
        req.deg_we     = 1'b1;
        req.deg_waddr  = vb;
        req.deg_wdata  = deg_b + 1'b1;
        req.cnt_raddr  = cnt_addr(va, cb);
      end
      ST_L3: begin
        req.cnt_we    = 1'b1;
        req.cnt_waddr = cnt_addr(va, cb);
        req.cnt_wdata = rd.cnt + 1'b1;
        req.cnt_raddr = cnt_addr(vb, cur);
      end
      ST_L4: begin
        req.cnt_we    = 1'b1;
        req.cnt_waddr = cnt_addr(vb, cur);
        req.cnt_wdata = rd.cnt + 1'b1;
      end
      default: ;
    endcase
  end

  // control state and totals
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      clr_addr       <= '0;
      conflicts      <= '0;
      best_conflicts <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) clr_addr <= clr_addr + 1'b1;
      if (state == ST_EVAL && apply) conflicts <= conf_upd;
      if (state == ST_L4 && cur == cb) conflicts <= conflicts + 1'b1;
      if (state == ST_FIN) begin
        if (op == OP_SET_COLOR || op == OP_ADD_EDGE) best_conflicts <= conflicts;
        else if (op == OP_PROPOSE && accepted && conflicts < best_conflicts)
          best_conflicts <= conflicts;
      end
    end
  end

  // item payload and work registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        op    <= op_t'(operation);
        va    <= vertex_a;
        vb    <= vertex_b;
        col   <= color;
        bound <= accept_bound;
      end
      ST_FETCH: begin
        accepted  <= 1'b0;
        delta     <= '0;
        list_full <= 1'b0;
      end
      ST_DECODE: begin
        cur   <= rd.col;
        deg_a <= rd.deg;
        k     <= '0;
      end
      ST_RD_OLD: cnt_new <= rd.cnt;
      ST_EVAL: begin
        if (op == OP_PROPOSE && considered) delta <= delta_w;
        accepted <= (op == OP_PROPOSE) && apply;
      end
      ST_W_OLD: nbr <= rd.list;
      ST_W_INC: k <= k + 1'b1;
      ST_S_CMP: k <= k + 1'b1;
      ST_GOT_B: begin
        cb        <= rd.col;
        deg_b     <= rd.deg;
        list_full <= full_w;
      end
      default: ;
    endcase
  end

endmodule
